@@ src/mhk_pkg.sv @@
// shared types, constants and lookup functions for the morse hex keyer
// used by mhk_shifter, mhk_seq and morse_hex_keyer; depends on nothing else
package mhk_pkg;

  localparam int unsigned MAX_PATTERN_UNITS = 19;
  localparam int unsigned GAP_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP = 2'd2;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_HEX = 1'b1;

  typedef logic [MAX_PATTERN_UNITS-1:0] pattern_t;

  typedef struct packed {
    logic       command;
    logic [7:0] value;
    logic       last_of_message;
  } in_word_t;

  typedef struct packed {
    logic key_on;
    logic last_unit;
  } out_word_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_LOAD_PAT,
    SH_LOAD_GAP,
    SH_STEP
  } sh_op_e;

  typedef struct packed {
    sh_op_e           op;
    logic [7:0]       code;
    logic [GAP_W-1:0] gap;
  } sh_ctrl_t;

  typedef struct packed {
    logic done;
    logic key;
  } sh_stat_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } emit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAT_HI,
    ST_GAP_HI,
    ST_PAT_LO,
    ST_GAP_LO,
    ST_BYTE_GAP,
    ST_WORD_GAP,
    ST_FLUSH
  } state_e;

  localparam logic [31:0] DIGIT_PAT [10] = '{
    32'h77777, 32'h1DDDD, 32'h7775, 32'h1DD5, 32'h755,
    32'h155, 32'h557, 32'h1577, 32'h5777, 32'h17777
  };

  localparam logic [31:0] LETTER_PAT [26] = '{
    32'h1D, 32'h157, 32'h5D7, 32'h57, 32'h1, 32'h175, 32'h177, 32'h55,
    32'h5, 32'h1DDD, 32'h1D7, 32'h15D, 32'h77, 32'h17, 32'h777, 32'h5DD,
    32'h1D77, 32'h5D, 32'h15, 32'h7, 32'h75, 32'h1D5, 32'h1DD, 32'h757,
    32'h1DD7, 32'h577
  };

  // on/off pattern, first unit in bit 0; unknown codes give no pattern
  function automatic pattern_t pattern_of(input logic [7:0] c);
    logic [7:0]  off;
    logic [31:0] p;
    off = 8'h00;
    p = 32'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      off = c - 8'h30;
      p = DIGIT_PAT[off[3:0]];
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      off = c - 8'h41;
      p = LETTER_PAT[off[4:0]];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      off = c - 8'h61;
      p = LETTER_PAT[off[4:0]];
    end
    return p[MAX_PATTERN_UNITS-1:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h41 + {4'h0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

@@ src/mhk_shifter.sv @@
// shared shift / count unit: shifts a character pattern out one unit per step,
// or counts down a run of low units; uses mhk_pkg
module mhk_shifter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mhk_pkg::sh_ctrl_t ctrl_i,
  output mhk_pkg::sh_stat_t stat_o
);

  mhk_pkg::pattern_t           pat_q, pat_d;
  logic [mhk_pkg::GAP_W-1:0]   cnt_q, cnt_d;
  logic                        gap_q, gap_d;

  always_comb begin
    pat_d = pat_q;
    cnt_d = cnt_q;
    gap_d = gap_q;
    unique case (ctrl_i.op)
      mhk_pkg::SH_LOAD_PAT: begin
        pat_d = mhk_pkg::pattern_of(ctrl_i.code);
        gap_d = 1'b0;
      end
      mhk_pkg::SH_LOAD_GAP: begin
        cnt_d = ctrl_i.gap;
        gap_d = 1'b1;
      end
      mhk_pkg::SH_STEP: begin
        if (gap_q) begin
          cnt_d = cnt_q - {{(mhk_pkg::GAP_W-1){1'b0}}, 1'b1};
        end else begin
          pat_d = pat_q >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      gap_q <= 1'b1;
    end else begin
      cnt_q <= cnt_d;
      gap_q <= gap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
  end

  // pattern is finished once no set bit remains; a gap once its count is zero
  assign stat_o.done = gap_q ? (cnt_q == '0) : (pat_q == '0);
  assign stat_o.key  = ~gap_q & pat_q[0];

endmodule

@@ src/mhk_seq.sv @@
// sequencer: walks pattern and gap phases of one word through mhk_shifter and
// holds back one unit so the final one can be marked; uses mhk_pkg
module mhk_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  mhk_pkg::in_word_t             in_data_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    char_gap_i,
  input  logic [mhk_pkg::GAP_W-1:0]     byte_gap_i,
  input  logic [mhk_pkg::GAP_W-1:0]     word_gap_i,
  input  logic                          adv_i,
  output mhk_pkg::emit_t                emit_o
);

  mhk_pkg::state_e   state_q, state_d;
  mhk_pkg::in_word_t word_q;
  mhk_pkg::sh_ctrl_t ctrl;
  mhk_pkg::sh_stat_t stat;
  logic              pend_v_q, pend_key_q;
  logic              unit_v, unit_key, flush, accept;

  mhk_shifter u_shifter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  assign in_stall_o = (state_q != mhk_pkg::ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d   = state_q;
    ctrl.op   = mhk_pkg::SH_HOLD;
    ctrl.code = '0;
    ctrl.gap  = '0;
    unit_v    = 1'b0;
    unit_key  = stat.key;
    flush     = 1'b0;
    unique case (state_q)
      mhk_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ctrl.op = mhk_pkg::SH_LOAD_PAT;
          if (in_data_i.command == mhk_pkg::CMD_HEX) begin
            ctrl.code = mhk_pkg::hex_char(in_data_i.value[7:4]);
            state_d   = mhk_pkg::ST_PAT_HI;
          end else begin
            ctrl.code = in_data_i.value;
            state_d   = mhk_pkg::ST_PAT_LO;
          end
        end
      end
      mhk_pkg::ST_PAT_HI: begin
        if (adv_i) begin
          if (!stat.done) begin
            ctrl.op = mhk_pkg::SH_STEP;
            unit_v  = 1'b1;
          end else begin
            ctrl.op  = mhk_pkg::SH_LOAD_GAP;
            ctrl.gap = {1'b0, char_gap_i};
            state_d  = mhk_pkg::ST_GAP_HI;
          end
        end
      end
      mhk_pkg::ST_GAP_HI: begin
        if (adv_i) begin
          if (!stat.done) begin
            ctrl.op = mhk_pkg::SH_STEP;
            unit_v  = 1'b1;
          end else begin
            ctrl.op   = mhk_pkg::SH_LOAD_PAT;
            ctrl.code = mhk_pkg::hex_char(word_q.value[3:0]);
            state_d   = mhk_pkg::ST_PAT_LO;
          end
        end
      end
      mhk_pkg::ST_PAT_LO: begin
        if (adv_i) begin
          if (!stat.done) begin
            ctrl.op = mhk_pkg::SH_STEP;
            unit_v  = 1'b1;
          end else begin
            ctrl.op  = mhk_pkg::SH_LOAD_GAP;
            ctrl.gap = {1'b0, char_gap_i};
            state_d  = mhk_pkg::ST_GAP_LO;
          end
        end
      end
      mhk_pkg::ST_GAP_LO: begin
        if (adv_i) begin
          if (!stat.done) begin
            ctrl.op = mhk_pkg::SH_STEP;
            unit_v  = 1'b1;
          end else if (word_q.command == mhk_pkg::CMD_HEX) begin
            ctrl.op  = mhk_pkg::SH_LOAD_GAP;
            ctrl.gap = byte_gap_i;
            state_d  = mhk_pkg::ST_BYTE_GAP;
          end else if (word_q.last_of_message) begin
            ctrl.op  = mhk_pkg::SH_LOAD_GAP;
            ctrl.gap = word_gap_i;
            state_d  = mhk_pkg::ST_WORD_GAP;
          end else begin
            state_d = mhk_pkg::ST_FLUSH;
          end
        end
      end
      mhk_pkg::ST_BYTE_GAP: begin
        if (adv_i) begin
          if (!stat.done) begin
            ctrl.op = mhk_pkg::SH_STEP;
            unit_v  = 1'b1;
          end else if (word_q.last_of_message) begin
            ctrl.op  = mhk_pkg::SH_LOAD_GAP;
            ctrl.gap = word_gap_i;
            state_d  = mhk_pkg::ST_WORD_GAP;
          end else begin
            state_d = mhk_pkg::ST_FLUSH;
          end
        end
      end
      mhk_pkg::ST_WORD_GAP: begin
        if (adv_i) begin
          if (!stat.done) begin
            ctrl.op = mhk_pkg::SH_STEP;
            unit_v  = 1'b1;
          end else begin
            state_d = mhk_pkg::ST_FLUSH;
          end
        end
      end
      mhk_pkg::ST_FLUSH: begin
        if (adv_i) begin
          flush   = 1'b1;
          state_d = mhk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mhk_pkg::ST_IDLE;
      end
    endcase
  end

  // the held unit goes out when a newer one arrives, or marked last on flush
  assign emit_o.valid          = pend_v_q & (unit_v | flush);
  assign emit_o.word.key_on    = pend_key_q;
  assign emit_o.word.last_unit = flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mhk_pkg::ST_IDLE;
      pend_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (unit_v) begin
        pend_v_q <= 1'b1;
      end else if (flush) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_data_i;
    end
    if (unit_v) begin
      pend_key_q <= unit_key;
    end
  end

endmodule

@@ src/morse_hex_keyer.sv @@
// morse hex keyer top level: gap registers, write port and output register
// depends on mhk_pkg, mhk_seq and mhk_shifter
// flow: a new word is taken only once the sequencer is idle again; the shared
// shift unit produces one key unit per cycle while the output is not stalled
// reset: gap registers return to 3 / 0 / 7, sequencer idle, output empty
module morse_hex_keyer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  mhk_pkg::in_word_t                 in_data_i,
  output logic                              in_stall_o,
  output logic                              out_valid_o,
  output mhk_pkg::out_word_t                out_data_o,
  input  logic                              out_stall_i,
  input  logic                              cfg_we_i,
  input  logic [mhk_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mhk_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  logic [1:0]                char_gap_q;
  logic [mhk_pkg::GAP_W-1:0] byte_gap_q, word_gap_q;
  logic                      out_v_q, out_v_d;
  mhk_pkg::out_word_t        out_q;
  mhk_pkg::emit_t            emit;
  logic                      adv;

  // sequencer moves only when the output register can take a word
  assign adv = ~out_v_q | ~out_stall_i;

  mhk_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .char_gap_i (char_gap_q),
    .byte_gap_i (byte_gap_q),
    .word_gap_i (word_gap_q),
    .adv_i      (adv),
    .emit_o     (emit)
  );

  always_comb begin
    out_v_d = out_v_q;
    if (adv) begin
      out_v_d = emit.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q    <= 1'b0;
      char_gap_q <= 2'd3;
      byte_gap_q <= 3'd0;
      word_gap_q <= 3'd7;
    end else begin
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mhk_pkg::CFG_CHAR_GAP: char_gap_q <= cfg_wdata_i[1:0];
          mhk_pkg::CFG_BYTE_GAP: byte_gap_q <= cfg_wdata_i;
          mhk_pkg::CFG_WORD_GAP: word_gap_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit.valid) begin
      out_q <= emit.word;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
